FILE: rtl/core/hrsp_pkg.sv
package hrsp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_HUE_START = 2'd0;
    localparam logic [1:0] CFG_HUE_END   = 2'd1;
    localparam logic [1:0] CFG_HUE_SHIFT = 2'd2;

    // which channel holds the maximum
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // number of quotient bits produced by the divider stages
    localparam int DIV_STAGES = 23;
    localparam int HQ_BITS    = 14;

    // 100 percent, 16 fraction bits
    localparam logic [22:0] PCT_ONE    = 23'd6553600;
    localparam logic [31:0] PCT_TWO    = 32'd13107200;
    localparam logic [22:0] HUE_SEC_X2 = 23'd30720;

    // value: mx*6553600/255 = 25700*mx + (100*mx + 127)/255, rounded
    localparam logic [14:0] V_STEP  = 15'd25700;
    localparam logic [14:0] V_REM   = 15'd100;
    localparam logic [14:0] V_ROUND = 15'd127;

    // hue positions, 8 fraction bits
    localparam logic [16:0] HUE_120 = 17'd30720;
    localparam logic [16:0] HUE_240 = 17'd61440;
    localparam logic [16:0] HUE_360 = 17'd92160;
    localparam logic [19:0] HUE_FULL_X1 = 20'd92160;
    localparam logic [19:0] HUE_FULL_X2 = 20'd184320;
    localparam logic [19:0] HUE_FULL_X3 = 20'd276480;
    localparam logic [19:0] HUE_FULL_X4 = 20'd368640;
    localparam logic [16:0] HUE_SEC_1 = 17'd15360;
    localparam logic [16:0] HUE_SEC_2 = 17'd30720;
    localparam logic [16:0] HUE_SEC_3 = 17'd46080;
    localparam logic [16:0] HUE_SEC_4 = 17'd61440;
    localparam logic [16:0] HUE_SEC_5 = 17'd76800;

    // reciprocals: floor(2^36/100) and floor(2^31/15)
    localparam logic [29:0] RECIP100 = 30'd687194767;
    localparam int          SH100    = 36;
    localparam logic [27:0] RECIP15  = 28'd143165576;
    localparam int          SH15     = 31;

    typedef struct packed {
        logic [7:0] alpha;
        logic [1:0] sel;
        logic       neg;
        logic       mx_zero;
        logic       gray;
    } t_side;

    // estimate may be one low; one compare puts it right
    function automatic logic [23:0] div100_fix(logic [29:0] y, logic [23:0] q0);
        logic [30:0] rr;
        rr = 31'(y) - 31'(q0) * 31'd100;
        return (rr >= 31'd100) ? q0 + 24'd1 : q0;
    endfunction

endpackage

FILE: rtl/core/hue_range_shift_pixel.sv
// channel  | dir | fields (lowest bit first)
// s_axis   | in  | tdata: red_in, green_in, blue_in, alpha_in
// m_axis   | out | tdata: red_out, green_out, blue_out, alpha_out; tuser: was_shifted
// cfg      | in  | index 0 hue_start, 1 hue_end, 2 hue_shift
// one word per clock while m_axis does not hold the pipe; a word passes p1, the
// divider setup, the 23 restoring divider stages that give saturation and hue in
// parallel, the back conversion stages e1 to e8 and the output register.
// reset clears the valid bits and the config registers; no clearing pass.
// a waiting result holds the whole pipe and the input, bubbles included.
module hue_range_shift_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic [0:0]  m_axis_tuser,   // was_shifted
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    import hrsp_pkg::*;

    logic       w_en;
    logic [8:0] r_hue_start;
    logic [8:0] r_hue_end;
    logic [9:0] r_hue_shift;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_start <= '0;
            r_hue_end   <= '0;
            r_hue_shift <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HUE_START: r_hue_start <= i_cfg_data[8:0];
                CFG_HUE_END:   r_hue_end   <= i_cfg_data[8:0];
                CFG_HUE_SHIFT: r_hue_shift <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage p1: max, min, difference ----------------
    logic [7:0] w_r, w_g, w_b, w_mx, w_mn;
    logic [7:0] n_p1_abs;
    logic [1:0] n_p1_sel;
    logic       n_p1_neg;
    logic       r_p1_vld;
    logic [7:0] r_p1_mx, r_p1_delta, r_p1_abs, r_p1_alpha;
    logic [1:0] r_p1_sel;
    logic       r_p1_neg;

    assign w_r = s_axis_tdata[7:0];
    assign w_g = s_axis_tdata[15:8];
    assign w_b = s_axis_tdata[23:16];

    always_comb begin
        w_mx = w_r;
        w_mn = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        if (w_mx == w_g) begin
            n_p1_sel = SEL_GREEN;
            n_p1_neg = w_b < w_r;
            n_p1_abs = n_p1_neg ? w_r - w_b : w_b - w_r;
        end else if (w_mx == w_b) begin
            n_p1_sel = SEL_BLUE;
            n_p1_neg = w_r < w_g;
            n_p1_abs = n_p1_neg ? w_g - w_r : w_r - w_g;
        end else begin
            n_p1_sel = SEL_RED;
            n_p1_neg = w_g < w_b;
            n_p1_abs = n_p1_neg ? w_b - w_g : w_g - w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_mx    <= w_mx;
            r_p1_delta <= w_mx - w_mn;
            r_p1_abs   <= n_p1_abs;
            r_p1_sel   <= n_p1_sel;
            r_p1_neg   <= n_p1_neg;
            r_p1_alpha <= s_axis_tdata[31:24];
        end
    end

    // ---------------- divider: setup and one quotient bit per stage ----------------
    logic [31:0]        r_srem [0:DIV_STAGES];
    logic [8:0]         r_sd   [0:DIV_STAGES];
    logic [22:0]        r_sq   [0:DIV_STAGES];
    logic [22:0]        r_vq   [0:DIV_STAGES];
    logic [22:0]        r_hrem [0:DIV_STAGES];
    logic [8:0]         r_hd   [0:DIV_STAGES];
    logic [HQ_BITS-1:0] r_hq   [0:DIV_STAGES];
    t_side              r_side [0:DIV_STAGES];
    logic [DIV_STAGES:0] r_dvld;
    logic [14:0]        w_vx, w_vf;

    // x/255 as (x + x/256 + 1)/256, exact below 65535
    assign w_vx = V_REM * 15'(r_p1_mx) + V_ROUND;
    assign w_vf = (w_vx + (w_vx >> 8) + 15'd1) >> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else if (w_en) begin
            r_dvld[0] <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_srem[0] <= 32'(r_p1_delta) * PCT_TWO + 32'(r_p1_mx);
            r_sd[0]   <= {r_p1_mx, 1'b0};
            r_sq[0]   <= '0;
            r_vq[0]   <= 23'(V_STEP) * 23'(r_p1_mx) + 23'(w_vf);
            r_hrem[0] <= 23'(r_p1_abs) * HUE_SEC_X2 + 23'(r_p1_delta);
            r_hd[0]   <= {r_p1_delta, 1'b0};
            r_hq[0]   <= '0;
            r_side[0] <= '{alpha: r_p1_alpha, sel: r_p1_sel, neg: r_p1_neg,
                           mx_zero: (r_p1_mx == 8'd0), gray: (r_p1_delta == 8'd0)};
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        localparam int B = DIV_STAGES - k;
        logic [32:0] n_sdif;

        assign n_sdif = {1'b0, r_srem[k-1]} - (33'(r_sd[k-1]) << B);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[k] <= 1'b0;
            end else if (w_en) begin
                r_dvld[k] <= r_dvld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sd[k]   <= r_sd[k-1];
                r_hd[k]   <= r_hd[k-1];
                r_side[k] <= r_side[k-1];
                r_srem[k] <= n_sdif[32] ? r_srem[k-1] : n_sdif[31:0];
                r_sq[k]   <= r_sq[k-1] | (23'(!n_sdif[32]) << B);
                r_vq[k]   <= r_vq[k-1];
            end
        end

        if (B < HQ_BITS) begin : g_hue
            logic [23:0] n_hdif;
            assign n_hdif = {1'b0, r_hrem[k-1]} - (24'(r_hd[k-1]) << B);
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_hrem[k] <= n_hdif[23] ? r_hrem[k-1] : n_hdif[22:0];
                    r_hq[k]   <= r_hq[k-1] | (HQ_BITS'(!n_hdif[23]) << B);
                end
            end
        end else begin : g_hue_pass
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_hrem[k] <= r_hrem[k-1];
                    r_hq[k]   <= r_hq[k-1];
                end
            end
        end
    end

    // ---------------- e1: hue, range test, (1-s)*v ----------------
    t_side       w_dside;
    logic [22:0] w_s;
    logic [16:0] w_off, n_e1_h, w_lo, w_hi;
    logic        n_e1_in;
    logic        r_e1_vld, r_e1_in;
    logic [16:0] r_e1_h;
    logic [45:0] r_e1_p;
    logic [22:0] r_e1_v;
    logic [7:0]  r_e1_alpha;

    assign w_dside = r_side[DIV_STAGES];
    assign w_s     = w_dside.mx_zero ? 23'd0 : r_sq[DIV_STAGES];
    assign w_lo    = {r_hue_start, 8'd0};
    assign w_hi    = {r_hue_end, 8'd0};

    always_comb begin
        case (w_dside.sel)
            SEL_GREEN: w_off = HUE_120;
            SEL_BLUE:  w_off = HUE_240;
            default:   w_off = w_dside.neg ? HUE_360 : 17'd0;
        endcase
        if (w_dside.gray) begin
            n_e1_h = 17'd0;
        end else if (w_dside.neg) begin
            n_e1_h = w_off - 17'(r_hq[DIV_STAGES]);
        end else begin
            n_e1_h = w_off + 17'(r_hq[DIV_STAGES]);
        end
        if (r_hue_start < r_hue_end) begin
            n_e1_in = (n_e1_h >= w_lo) && (n_e1_h <= w_hi);
        end else if (r_hue_start > r_hue_end) begin
            n_e1_in = (n_e1_h >= w_lo) || (n_e1_h <= w_hi);
        end else begin
            n_e1_in = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else if (w_en) begin
            r_e1_vld <= r_dvld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_h     <= n_e1_h;
            r_e1_in    <= n_e1_in;
            r_e1_p     <= 46'(PCT_ONE - w_s) * 46'(r_vq[DIV_STAGES]);
            r_e1_v     <= r_vq[DIV_STAGES];
            r_e1_alpha <= w_dside.alpha;
        end
    end

    // ---------------- e2: hue shift and wrap, vmin estimate ----------------
    logic [19:0] w_t;
    logic [16:0] n_e2_hu;
    logic [46:0] w_x1;
    logic        r_e2_vld, r_e2_in;
    logic [16:0] r_e2_hu;
    logic [29:0] r_e2_y1;
    logic [59:0] r_e2_prod;
    logic [22:0] r_e2_v;
    logic [7:0]  r_e2_alpha;

    assign w_t  = 20'(r_e1_h) + HUE_FULL_X2 + {{2{r_hue_shift[9]}}, r_hue_shift, 8'd0};
    assign w_x1 = {r_e1_p, 1'b0} + 47'(PCT_ONE);

    always_comb begin
        if (!r_e1_in) begin
            n_e2_hu = r_e1_h;
        end else if (w_t >= HUE_FULL_X4) begin
            n_e2_hu = 17'(w_t - HUE_FULL_X4);
        end else if (w_t >= HUE_FULL_X3) begin
            n_e2_hu = 17'(w_t - HUE_FULL_X3);
        end else if (w_t >= HUE_FULL_X2) begin
            n_e2_hu = 17'(w_t - HUE_FULL_X2);
        end else if (w_t >= HUE_FULL_X1) begin
            n_e2_hu = 17'(w_t - HUE_FULL_X1);
        end else begin
            n_e2_hu = 17'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_vld <= 1'b0;
        end else if (w_en) begin
            r_e2_vld <= r_e1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_in    <= r_e1_in;
            r_e2_hu    <= n_e2_hu;
            r_e2_y1    <= w_x1[46:17];
            r_e2_prod  <= 60'(w_x1[46:17]) * 60'(RECIP100);
            r_e2_v     <= r_e1_v;
            r_e2_alpha <= r_e1_alpha;
        end
    end

    // ---------------- e3: vmin, sector and fraction ----------------
    logic [2:0]  n_e3_sec;
    logic [16:0] n_e3_frac;
    logic [23:0] w_vmin;
    logic        r_e3_vld, r_e3_in;
    logic [22:0] r_e3_vmin, r_e3_v;
    logic [2:0]  r_e3_sec;
    logic [13:0] r_e3_frac;
    logic [7:0]  r_e3_alpha;

    assign w_vmin = div100_fix(r_e2_y1, r_e2_prod[SH100 +: 24]);

    always_comb begin
        if (r_e2_hu >= HUE_SEC_5) begin
            n_e3_sec  = 3'd5;
            n_e3_frac = r_e2_hu - HUE_SEC_5;
        end else if (r_e2_hu >= HUE_SEC_4) begin
            n_e3_sec  = 3'd4;
            n_e3_frac = r_e2_hu - HUE_SEC_4;
        end else if (r_e2_hu >= HUE_SEC_3) begin
            n_e3_sec  = 3'd3;
            n_e3_frac = r_e2_hu - HUE_SEC_3;
        end else if (r_e2_hu >= HUE_SEC_2) begin
            n_e3_sec  = 3'd2;
            n_e3_frac = r_e2_hu - HUE_SEC_2;
        end else if (r_e2_hu >= HUE_SEC_1) begin
            n_e3_sec  = 3'd1;
            n_e3_frac = r_e2_hu - HUE_SEC_1;
        end else begin
            n_e3_sec  = 3'd0;
            n_e3_frac = r_e2_hu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_vld <= 1'b0;
        end else if (w_en) begin
            r_e3_vld <= r_e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e3_in    <= r_e2_in;
            r_e3_vmin  <= w_vmin[22:0];
            r_e3_v     <= r_e2_v;
            r_e3_sec   <= n_e3_sec;
            r_e3_frac  <= n_e3_frac[13:0];
            r_e3_alpha <= r_e2_alpha;
        end
    end

    // ---------------- e4: (v - vmin) * f ----------------
    logic        r_e4_vld, r_e4_in;
    logic [36:0] r_e4_m;
    logic [22:0] r_e4_vmin, r_e4_v;
    logic [2:0]  r_e4_sec;
    logic [7:0]  r_e4_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_vld <= 1'b0;
        end else if (w_en) begin
            r_e4_vld <= r_e3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e4_in    <= r_e3_in;
            r_e4_m     <= 37'(r_e3_v - r_e3_vmin) * 37'(r_e3_frac);
            r_e4_vmin  <= r_e3_vmin;
            r_e4_v     <= r_e3_v;
            r_e4_sec   <= r_e3_sec;
            r_e4_alpha <= r_e3_alpha;
        end
    end

    // ---------------- e5: divide by one sector, estimate ----------------
    logic [37:0] w_x2;
    logic        r_e5_vld, r_e5_in;
    logic [26:0] r_e5_y2;
    logic [54:0] r_e5_prod;
    logic [22:0] r_e5_vmin, r_e5_v;
    logic [2:0]  r_e5_sec;
    logic [7:0]  r_e5_alpha;

    assign w_x2 = {r_e4_m, 1'b0} + 38'(HUE_SEC_1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e5_vld <= 1'b0;
        end else if (w_en) begin
            r_e5_vld <= r_e4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e5_in    <= r_e4_in;
            r_e5_y2    <= w_x2[37:11];
            r_e5_prod  <= 55'(w_x2[37:11]) * 55'(RECIP15);
            r_e5_vmin  <= r_e4_vmin;
            r_e5_v     <= r_e4_v;
            r_e5_sec   <= r_e4_sec;
            r_e5_alpha <= r_e4_alpha;
        end
    end

    // ---------------- e6: correct n ----------------
    logic [23:0] w_n0;
    logic [27:0] w_nr;
    logic [23:0] w_num;
    logic        r_e6_vld, r_e6_in;
    logic [22:0] r_e6_num, r_e6_vmin, r_e6_v;
    logic [2:0]  r_e6_sec;
    logic [7:0]  r_e6_alpha;

    assign w_n0  = r_e5_prod[SH15 +: 24];
    assign w_nr  = 28'(r_e5_y2) - 28'(w_n0) * 28'd15;
    assign w_num = (w_nr >= 28'd15) ? w_n0 + 24'd1 : w_n0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e6_vld <= 1'b0;
        end else if (w_en) begin
            r_e6_vld <= r_e5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e6_in    <= r_e5_in;
            r_e6_num   <= w_num[22:0];
            r_e6_vmin  <= r_e5_vmin;
            r_e6_v     <= r_e5_v;
            r_e6_sec   <= r_e5_sec;
            r_e6_alpha <= r_e5_alpha;
        end
    end

    // ---------------- e7: six-sector select ----------------
    logic [22:0] w_vinc, w_vdec;
    logic [22:0] n_e7_c [0:2];
    logic        r_e7_vld, r_e7_in;
    logic [22:0] r_e7_c [0:2];
    logic [7:0]  r_e7_alpha;

    assign w_vinc = r_e6_vmin + r_e6_num;
    assign w_vdec = r_e6_v - r_e6_num;

    always_comb begin
        case (r_e6_sec)
            3'd0: begin
                n_e7_c[0] = r_e6_v;    n_e7_c[1] = w_vinc;    n_e7_c[2] = r_e6_vmin;
            end
            3'd1: begin
                n_e7_c[0] = w_vdec;    n_e7_c[1] = r_e6_v;    n_e7_c[2] = r_e6_vmin;
            end
            3'd2: begin
                n_e7_c[0] = r_e6_vmin; n_e7_c[1] = r_e6_v;    n_e7_c[2] = w_vinc;
            end
            3'd3: begin
                n_e7_c[0] = r_e6_vmin; n_e7_c[1] = w_vdec;    n_e7_c[2] = r_e6_v;
            end
            3'd4: begin
                n_e7_c[0] = w_vinc;    n_e7_c[1] = r_e6_vmin; n_e7_c[2] = r_e6_v;
            end
            default: begin
                n_e7_c[0] = r_e6_v;    n_e7_c[1] = r_e6_vmin; n_e7_c[2] = w_vdec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e7_vld <= 1'b0;
        end else if (w_en) begin
            r_e7_vld <= r_e6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e7_in    <= r_e6_in;
            r_e7_c     <= n_e7_c;
            r_e7_alpha <= r_e6_alpha;
        end
    end

    // ---------------- e8 and output: scale to 8 bits ----------------
    logic        r_e8_vld, r_e8_in;
    logic [15:0] r_e8_y [0:2];
    logic [45:0] r_e8_prod [0:2];
    logic [7:0]  r_e8_alpha;
    logic [7:0]  w_ch [0:2];
    logic        r_o_vld, r_o_in;
    logic [31:0] r_o_data;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [32:0] w_x3;
        logic [23:0] w_q;

        assign w_x3 = 33'(r_e7_c[c]) * 33'd510 + 33'(PCT_ONE);
        assign w_q  = div100_fix(30'(r_e8_y[c]), 24'(r_e8_prod[c][45:SH100]));
        assign w_ch[c] = (w_q > 24'd255) ? 8'd255 : w_q[7:0];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_e8_y[c]    <= w_x3[32:17];
                r_e8_prod[c] <= 46'(w_x3[32:17]) * 46'(RECIP100);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e8_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_e8_vld <= r_e7_vld;
            r_o_vld  <= r_e8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e8_in    <= r_e7_in;
            r_e8_alpha <= r_e7_alpha;
            r_o_in     <= r_e8_in;
            r_o_data   <= {r_e8_alpha, w_ch[2], w_ch[1], w_ch[0]};
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_in;

endmodule

FILE: test/hue_range_shift_pixel_chk.sv
module hue_range_shift_pixel_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hrsp_pkg::*;

    typedef struct packed {
        logic       shifted;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_pix;

    t_pix pix_q[$];
    logic [8:0] hue_lo;
    logic [8:0] hue_hi;
    logic signed [9:0] hue_add;

    function automatic longint rdiv(longint n, longint d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic longint chan(longint c);
        longint v;
        v = rdiv(c * 255, 6553600);
        return v > 255 ? 255 : v;
    endfunction

    function automatic longint hpart(longint diff, longint delta);
        longint q;
        q = rdiv((diff < 0 ? -diff : diff) * 15360, delta);
        return diff < 0 ? -q : q;
    endfunction

    function automatic t_pix shift_hue(logic [31:0] d);
        longint r, g, b, mx, mn, delta, vv, ss, h, vmin, num, vinc, vdec;
        longint cr, cg, cb, sector, frac;
        logic in_rng;
        t_pix p;
        r = d[7:0];
        g = d[15:8];
        b = d[23:16];
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        vv = rdiv(mx * 6553600, 255);
        ss = (mx == 0) ? 0 : rdiv(delta * 6553600, mx);
        if (delta == 0) h = 0;
        else if (mx == g) h = 30720 + hpart(b - r, delta);
        else if (mx == b) h = 61440 + hpart(r - g, delta);
        else if (g < b) h = 92160 + hpart(g - b, delta);
        else h = hpart(g - b, delta);
        in_rng = 0;
        if (hue_lo < hue_hi) in_rng = (h >= hue_lo * 256) && (h <= hue_hi * 256);
        else if (hue_lo > hue_hi) in_rng = (h >= hue_lo * 256) || (h <= hue_hi * 256);
        if (in_rng) h = (h + longint'(hue_add) * 256 + 184320) % 92160;
        sector = h / 15360;
        frac = h % 15360;
        vmin = rdiv((6553600 - ss) * vv, 6553600);
        num = rdiv((vv - vmin) * frac, 15360);
        vinc = vmin + num;
        vdec = vv - num;
        case (sector)
            0: begin cr = vv; cg = vinc; cb = vmin; end
            1: begin cr = vdec; cg = vv; cb = vmin; end
            2: begin cr = vmin; cg = vv; cb = vinc; end
            3: begin cr = vmin; cg = vdec; cb = vv; end
            4: begin cr = vinc; cg = vmin; cb = vv; end
            default: begin cr = vv; cg = vmin; cb = vdec; end
        endcase
        p.r = 8'(chan(cr));
        p.g = 8'(chan(cg));
        p.b = 8'(chan(cb));
        p.a = d[31:24];
        p.shifted = in_rng;
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_pix w;
        if (!i_rst_n) begin
            hue_lo <= '0;
            hue_hi <= '0;
            hue_add <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HUE_START: hue_lo <= i_cfg_data[8:0];
                    CFG_HUE_END:   hue_hi <= i_cfg_data[8:0];
                    CFG_HUE_SHIFT: hue_add <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) pix_q.push_back(shift_hue(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (pix_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata, 0);
                end else begin
                    w = pix_q.pop_front();
                    if (m_axis_tdata[7:0] != w.r) report_mismatch("red", m_axis_tdata[7:0], w.r);
                    if (m_axis_tdata[15:8] != w.g)
                        report_mismatch("green", m_axis_tdata[15:8], w.g);
                    if (m_axis_tdata[23:16] != w.b)
                        report_mismatch("blue", m_axis_tdata[23:16], w.b);
                    if (m_axis_tdata[31:24] != w.a)
                        report_mismatch("alpha", m_axis_tdata[31:24], w.a);
                    if (m_axis_tuser[0] != w.shifted)
                        report_mismatch("was_shifted", m_axis_tuser[0], w.shifted);
                end
            end
        end
        o_pending = pix_q.size();
    end
endmodule

FILE: test/hue_range_shift_pixel_tb.sv
module hue_range_shift_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hrsp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [9:0]  i_cfg_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          hold_sink;

    hue_range_shift_pixel u_dut (.*);

    hue_range_shift_pixel_chk u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // sink with random stalls, one long hold-off on request
    initial begin
        int n;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 0;
                repeat (120) @(negedge i_clk);
                hold_sink = 0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                m_axis_tready <= 0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic send_pixel(logic [31:0] d, bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 8) : 0;
        if (n > 0) begin
            s_axis_tvalid <= 0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_all();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [9:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic set_range(int lo, int hi, int sh);
        set_reg(CFG_HUE_START, 10'(lo));
        set_reg(CFG_HUE_END, 10'(hi));
        set_reg(CFG_HUE_SHIFT, 10'(sh));
        i_cfg_we <= 0;
    endtask

    function automatic logic [31:0] rand_pixel();
        logic [31:0] d;
        d = $urandom;
        case ($urandom_range(0, 7))
            0: d[23:0] = {3{d[7:0]}};          // gray
            1: d[23:16] = d[15:8];              // tie
            2: d[15:8] = d[7:0];
            3: d[7:0] = 8'd255;
            default: ;
        endcase
        return d;
    endfunction

    initial begin
        logic [31:0] dir_pix [] = '{32'h00000000, 32'hFFFFFFFF, 32'h00_0000FF, 32'hFF_00FF00,
            32'h80_FF0000, 32'h01_FFFF00, 32'h7F_00FFFF, 32'hC3_FF00FF, 32'h55_808080,
            32'hAA_FF00FE, 32'h10_0102FF, 32'h20_FF01FF, 32'h30_FFFF01, 32'h40_010000,
            32'h50_000100, 32'h60_123456, 32'h70_FEFDFC};
        int cfgs [6][3] = '{'{0, 0, 0}, '{0, 360, 360}, '{300, 60, -360},
                            '{90, 200, 180}, '{511, 0, 511}, '{180, 180, -1}};
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        hold_sink = 0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        foreach (dir_pix[k]) send_pixel(dir_pix[k], 0);
        drain_all();
        set_range(0, 360, 90);
        foreach (dir_pix[k]) send_pixel(dir_pix[k], 1);
        drain_all();
        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 6) set_range(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2]);
            else set_range($urandom_range(0, 511), $urandom_range(0, 511), $urandom);
            if (ph == 2) hold_sink = 1;
            for (int k = 0; k < 70; k++) send_pixel(rand_pixel(), ph != 2 && ph != 5);
            drain_all();
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
